>>> src/lphs_pkg.sv
package lphs_pkg;

   localparam int TABLE_SLOTS = 1024;
   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int REM_W = IDX_W + 2;
   localparam int KEY_W = 32;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_SLOTS - 1);
   localparam logic [REM_W-1:0] SLOTS_REM = REM_W'(TABLE_SLOTS);
   localparam logic [REM_W-1:0] SLOTS2_REM = REM_W'(2 * TABLE_SLOTS);
   localparam logic [KEY_W-1:0] HASH_RECIP = KEY_W'(64'h1_0000_0000 / 64'(TABLE_SLOTS));
   localparam logic [KEY_W-1:0] SLOTS_KEY = KEY_W'(TABLE_SLOTS);

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_COUNT  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MARK_DEAD   = 2'd0,
      MARK_FILLED = 2'd1,
      MARK_EMPTY  = 2'd2
   } mark_type;

   typedef struct packed {
      op_type           opcode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic hit;
      logic table_full;
   } rsp_type;

   typedef struct packed {
      logic             mark_en;
      logic             value_en;
      logic [IDX_W-1:0] addr;
      mark_type         mark;
      logic [KEY_W-1:0] value;
   } wr_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } done_type;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] pos);
      logic [IDX_W-1:0] nxt;
      nxt = (pos == LAST_SLOT) ? '0 : pos + 1'b1;
      return nxt;
   endfunction

endpackage

>>> src/linear_probe_hash_set.sv
// Each insert, erase or count probes 1 to TABLE_SLOTS slots before rsp_valid; no new request
// is taken until the current one is done. The home slot comes from the home-slot reduction
// pipeline (quotient, product, remainder registers), then the table memory is read one slot per cycle.
// Clear writes one mark per cycle through the table, setting every slot to empty, then responds.
// Reset: synchronous; after reset the table is swept to empty, during which req_stall
// stays high.
module linear_probe_hash_set (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lphs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lphs_pkg::rsp_type rsp_data
);

   logic                       rsp_valid_ff, rsp_valid_in;
   lphs_pkg::rsp_type          rsp_data_ff, rsp_data_in;
   logic                       out_free;
   logic                       hash_start, hash_done;
   logic [lphs_pkg::IDX_W-1:0] hash_home;
   logic [lphs_pkg::IDX_W-1:0] rd_addr;
   lphs_pkg::mark_type         rd_mark;
   logic [lphs_pkg::KEY_W-1:0] rd_value;
   lphs_pkg::wr_type           wr;
   lphs_pkg::done_type         done;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   lphs_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_data.key),
      .done  (hash_done),
      .home  (hash_home)
   );

   lphs_mem u_mem (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_mark  (rd_mark),
      .rd_value (rd_value)
   );

   lphs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .out_free   (out_free),
      .hash_start (hash_start),
      .hash_done  (hash_done),
      .hash_home  (hash_home),
      .wr         (wr),
      .rd_addr    (rd_addr),
      .rd_mark    (rd_mark),
      .rd_value   (rd_value),
      .done       (done)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done.data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> src/lphs_hash.sv
module lphs_hash (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lphs_pkg::KEY_W-1:0]      key,
   output logic                            done,
   output logic [lphs_pkg::IDX_W-1:0]      home
);

   logic                         v1_ff, v2_ff, v3_ff;
   logic [lphs_pkg::KEY_W-1:0]   key1_ff, key2_ff;
   logic [lphs_pkg::KEY_W-1:0]   quot_ff, quot_in;
   logic [lphs_pkg::KEY_W-1:0]   qn_ff, qn_in;
   logic [lphs_pkg::IDX_W-1:0]   home_ff, home_in;
   logic [2*lphs_pkg::KEY_W-1:0] prod;
   logic [2*lphs_pkg::KEY_W-1:0] prod_qn;
   logic [lphs_pkg::KEY_W-1:0]   diff;
   logic [lphs_pkg::REM_W-1:0]   rem;

   always_comb begin
      prod    = 64'(key) * 64'(lphs_pkg::HASH_RECIP);
      quot_in = prod[2*lphs_pkg::KEY_W-1:lphs_pkg::KEY_W];
      prod_qn = 64'(quot_ff) * 64'(lphs_pkg::SLOTS_KEY);
      qn_in   = prod_qn[lphs_pkg::KEY_W-1:0];
      diff    = key2_ff - qn_ff;
      rem     = diff[lphs_pkg::REM_W-1:0];
      if (rem >= lphs_pkg::SLOTS2_REM) begin
         rem = rem - lphs_pkg::SLOTS2_REM;
      end else if (rem >= lphs_pkg::SLOTS_REM) begin
         rem = rem - lphs_pkg::SLOTS_REM;
      end
      home_in = rem[lphs_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      quot_ff <= quot_in;
      key1_ff <= key;
      qn_ff   <= qn_in;
      key2_ff <= key1_ff;
      home_ff <= home_in;
   end

   assign done = v3_ff;
   assign home = home_ff;

endmodule

>>> src/lphs_mem.sv
module lphs_mem (
   input  logic                          clock,
   input  lphs_pkg::wr_type              wr,
   input  logic [lphs_pkg::IDX_W-1:0]    rd_addr,
   output lphs_pkg::mark_type            rd_mark,
   output logic [lphs_pkg::KEY_W-1:0]    rd_value
);

   lphs_pkg::mark_type         mark_mem [lphs_pkg::TABLE_SLOTS];
   logic [lphs_pkg::KEY_W-1:0] value_mem [lphs_pkg::TABLE_SLOTS];

   always_ff @(posedge clock) begin
      if (wr.mark_en) begin
         mark_mem[wr.addr] <= wr.mark;
      end
      rd_mark <= mark_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.value_en) begin
         value_mem[wr.addr] <= wr.value;
      end
      rd_value <= value_mem[rd_addr];
   end

endmodule

>>> src/lphs_ctrl.sv
module lphs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lphs_pkg::req_type             req_data,
   input  logic                          out_free,
   output logic                          hash_start,
   input  logic                          hash_done,
   input  logic [lphs_pkg::IDX_W-1:0]    hash_home,
   output lphs_pkg::wr_type              wr,
   output logic [lphs_pkg::IDX_W-1:0]    rd_addr,
   input  lphs_pkg::mark_type            rd_mark,
   input  logic [lphs_pkg::KEY_W-1:0]    rd_value,
   output lphs_pkg::done_type            done
);

   typedef enum logic [3:0] {
      ST_SWEEP = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_HASH  = 4'b0100,
      ST_PROBE = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   lphs_pkg::op_type           op_ff, op_in;
   logic [lphs_pkg::KEY_W-1:0] key_ff, key_in;
   logic [lphs_pkg::IDX_W-1:0] pos_ff, pos_in;
   logic [lphs_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic [lphs_pkg::IDX_W-1:0] free_ff, free_in;
   logic                       have_free_ff, have_free_in;
   logic                       report_ff, report_in;

   logic                       accept;
   logic                       is_filled, is_empty, match, last;
   logic                       free_any;
   logic [lphs_pkg::IDX_W-1:0] free_pos;

   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      is_filled = (rd_mark == lphs_pkg::MARK_FILLED);
      is_empty  = (rd_mark == lphs_pkg::MARK_EMPTY);
      match     = is_filled && (rd_value == key_ff);
      last      = (cnt_ff == lphs_pkg::LAST_SLOT);
      free_any  = have_free_ff || !is_filled;
      free_pos  = have_free_ff ? free_ff : pos_ff;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      free_in      = free_ff;
      have_free_in = have_free_ff;
      report_in    = report_ff;
      hash_start   = 1'b0;
      rd_addr      = lphs_pkg::next_slot(pos_ff);
      wr           = '{mark_en: 1'b0, value_en: 1'b0, addr: pos_ff,
                       mark: lphs_pkg::MARK_EMPTY, value: key_ff};
      done         = '0;

      unique case (state_ff)
         ST_SWEEP: begin
            wr.mark_en = 1'b1;
            wr.mark    = lphs_pkg::MARK_EMPTY;
            pos_in     = lphs_pkg::next_slot(pos_ff);
            if (pos_ff == lphs_pkg::LAST_SLOT) begin
               state_in   = ST_IDLE;
               done.valid = report_ff;
               report_in  = 1'b0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in  = req_data.opcode;
               key_in = req_data.key;
               if (req_data.opcode == lphs_pkg::OP_CLEAR) begin
                  state_in  = ST_SWEEP;
                  pos_in    = '0;
                  report_in = 1'b1;
               end else begin
                  state_in   = ST_HASH;
                  hash_start = 1'b1;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               rd_addr      = hash_home;
               pos_in       = hash_home;
               cnt_in       = '0;
               have_free_in = 1'b0;
               state_in     = ST_PROBE;
            end
         end
         ST_PROBE: begin
            pos_in = lphs_pkg::next_slot(pos_ff);
            cnt_in = cnt_ff + 1'b1;
            if (op_ff == lphs_pkg::OP_INSERT) begin
               if (match) begin
                  done.valid = 1'b1;
                  state_in   = ST_IDLE;
               end else if (is_empty || last) begin
                  done.valid = 1'b1;
                  state_in   = ST_IDLE;
                  if (free_any) begin
                     wr.mark_en    = 1'b1;
                     wr.value_en   = 1'b1;
                     wr.addr       = free_pos;
                     wr.mark       = lphs_pkg::MARK_FILLED;
                     done.data.hit = 1'b1;
                  end else begin
                     done.data.table_full = 1'b1;
                  end
               end else if (!have_free_ff && !is_filled) begin
                  have_free_in = 1'b1;
                  free_in      = pos_ff;
               end
            end else begin
               if (match) begin
                  done.valid    = 1'b1;
                  done.data.hit = 1'b1;
                  state_in      = ST_IDLE;
                  if (op_ff == lphs_pkg::OP_ERASE) begin
                     wr.mark_en = 1'b1;
                     wr.mark    = lphs_pkg::MARK_DEAD;
                  end
               end else if (is_empty || last) begin
                  done.valid = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_SWEEP;
            pos_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         pos_ff       <= '0;
         report_ff    <= 1'b0;
         have_free_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         report_ff    <= report_in;
         have_free_ff <= have_free_in;
      end
      op_ff   <= op_in;
      key_ff  <= key_in;
      cnt_ff  <= cnt_in;
      free_ff <= free_in;
   end

`ifndef ASSERT_OFF
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state register not one-hot");

   a_hash_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == ST_HASH)
      else $error("hash result outside hash wait");

   a_probe_write_addr: assert property (@(posedge clock) disable iff (reset)
      (wr.mark_en && state_ff == ST_PROBE) |->
         (wr.addr == pos_ff) || (have_free_ff && wr.addr == free_ff))
      else $error("probe write to a slot not visited");

   a_full_insert_only: assert property (@(posedge clock) disable iff (reset)
      (done.valid && done.data.table_full) |->
         (op_ff == lphs_pkg::OP_INSERT) && !done.data.hit && !wr.mark_en)
      else $error("table_full on a non-insert or with a write");
`endif

endmodule
